FILE: hw/rtl/spr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, codes and defaults for the shared page reference-count table.
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int ENTRIES_DEFAULT   = 8;
   localparam int PAGE_BITS_DEFAULT = 44;
   localparam int REF_BITS_DEFAULT  = 16;

   localparam int ID_BITS     = 32;
   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 3;

   localparam logic [MODE_BITS-1:0] MODE_OPEN  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CLOSE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_QUERY = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND  = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL       = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_ALLOC_FAIL = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW   = 3'd4;

   // Update applied to one entry when a request leaves the end of the row.
   localparam logic [1:0] CMT_INC  = 2'd0;
   localparam logic [1:0] CMT_DEC  = 2'd1;
   localparam logic [1:0] CMT_NEW  = 2'd2;
   localparam logic [1:0] CMT_FREE = 2'd3;

   // Control bits of a request walking down the row of cells.
   typedef struct packed {
      logic                 valid;
      logic [MODE_BITS-1:0] mode;
      logic                 hit;
      logic                 free_ok;
      logic                 shared;
   } pkt_type;

   typedef struct packed {
      logic       en;
      logic [1:0] op;
   } cmt_type;

endpackage
`default_nettype wire

FILE: hw/rtl/spr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spr_cell
// One table entry plus one stage of the search row; compares the passing
// request against its entry and applies the commit addressed to it.
// ----------------------------------------------------------------------------
module spr_cell #(
   parameter int IDX_BITS  = 3,
   parameter int MY_IDX    = 0,
   parameter int PAGE_BITS = spr_pkg::PAGE_BITS_DEFAULT,
   parameter int REF_BITS  = spr_pkg::REF_BITS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  spr_pkg::pkt_type              ctl_i,
   input  wire  [spr_pkg::ID_BITS-1:0]   id_i,
   input  wire  [PAGE_BITS-1:0]          fresh_i,
   input  wire  [PAGE_BITS-1:0]          qpage_i,
   input  wire  [IDX_BITS-1:0]           hit_idx_i,
   input  wire  [REF_BITS-1:0]           hit_refs_i,
   input  wire  [PAGE_BITS-1:0]          hit_page_i,
   input  wire  [IDX_BITS-1:0]           free_idx_i,
   output spr_pkg::pkt_type              ctl_o,
   output logic [spr_pkg::ID_BITS-1:0]   id_o,
   output logic [PAGE_BITS-1:0]          fresh_o,
   output logic [PAGE_BITS-1:0]          qpage_o,
   output logic [IDX_BITS-1:0]           hit_idx_o,
   output logic [REF_BITS-1:0]           hit_refs_o,
   output logic [PAGE_BITS-1:0]          hit_page_o,
   output logic [IDX_BITS-1:0]           free_idx_o,
   input  spr_pkg::cmt_type              cmt_i,
   input  wire  [IDX_BITS-1:0]           cmt_idx_i,
   input  wire  [spr_pkg::ID_BITS-1:0]   cmt_id_i,
   input  wire  [PAGE_BITS-1:0]          cmt_page_i
);

   localparam logic [IDX_BITS-1:0] ME = IDX_BITS'(MY_IDX);

   logic                        valid_ff, valid_in;
   logic [spr_pkg::ID_BITS-1:0] eid_ff, eid_in;
   logic [PAGE_BITS-1:0]        epage_ff, epage_in;
   logic [REF_BITS-1:0]         erefs_ff, erefs_in;

   spr_pkg::pkt_type            ctl_ff, ctl_in;
   logic [spr_pkg::ID_BITS-1:0] id_ff;
   logic [PAGE_BITS-1:0]        fresh_ff, qpage_ff, hit_page_ff, hit_page_in;
   logic [IDX_BITS-1:0]         hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [REF_BITS-1:0]         hit_refs_ff, hit_refs_in;

   logic id_match, take_hit, take_free, mine;

   assign id_match  = valid_ff && (eid_ff == id_i);
   assign take_hit  = !ctl_i.hit && id_match;
   assign take_free = !ctl_i.free_ok && !valid_ff;
   assign mine      = cmt_i.en && (cmt_idx_i == ME);

   always_comb begin
      ctl_in         = ctl_i;
      ctl_in.hit     = ctl_i.hit || id_match;
      ctl_in.free_ok = ctl_i.free_ok || !valid_ff;
      ctl_in.shared  = ctl_i.shared || (valid_ff && (epage_ff == qpage_i));
      hit_idx_in     = take_hit ? ME : hit_idx_i;
      hit_refs_in    = take_hit ? erefs_ff : hit_refs_i;
      hit_page_in    = take_hit ? epage_ff : hit_page_i;
      free_idx_in    = take_free ? ME : free_idx_i;
   end

   always_comb begin
      valid_in = valid_ff;
      eid_in   = eid_ff;
      epage_in = epage_ff;
      erefs_in = erefs_ff;
      if (mine) begin
         case (cmt_i.op)
            spr_pkg::CMT_INC: begin
               erefs_in = erefs_ff + REF_BITS'(1);
            end
            spr_pkg::CMT_DEC: begin
               erefs_in = erefs_ff - REF_BITS'(1);
            end
            spr_pkg::CMT_NEW: begin
               valid_in = 1'b1;
               eid_in   = cmt_id_i;
               epage_in = cmt_page_i;
               erefs_in = REF_BITS'(1);
            end
            spr_pkg::CMT_FREE: begin
               valid_in = 1'b0;
               erefs_in = '0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ctl_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ctl_ff   <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      eid_ff         <= eid_in;
      epage_ff       <= epage_in;
      erefs_ff       <= erefs_in;
      id_ff          <= id_i;
      fresh_ff       <= fresh_i;
      qpage_ff       <= qpage_i;
      hit_idx_ff     <= hit_idx_in;
      hit_refs_ff    <= hit_refs_in;
      hit_page_ff    <= hit_page_in;
      free_idx_ff    <= free_idx_in;
   end

   assign ctl_o      = ctl_ff;
   assign id_o       = id_ff;
   assign fresh_o    = fresh_ff;
   assign qpage_o    = qpage_ff;
   assign hit_idx_o  = hit_idx_ff;
   assign hit_refs_o = hit_refs_ff;
   assign hit_page_o = hit_page_ff;
   assign free_idx_o = free_idx_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/shared_page_refcount_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shared_page_refcount_table
// Table of shared pages with reference counts: open, close and query by a
// request that walks a row of entry cells, then one commit to the chosen entry.
// ----------------------------------------------------------------------------
//   channel | dir | handshake            | contents
//   req_    | in  | req_tvalid/tready    | tuser: mode; tdata: id, fresh, query
//   rsp_    | out | rsp_tvalid/tready    | tuser: status; tdata: result fields
//
// A request moves one cell per cycle down the row, and the update lands as it
// leaves the last cell. One request is in the row at a time; req_tready drops
// while it is there. A single result waiting on rsp_ does not block the next
// request; a second result parks in a skid register and holds req_tready low
// until it moves up. Reset clears all entry marks.
// ----------------------------------------------------------------------------
module shared_page_refcount_table #(
   parameter int ENTRIES   = spr_pkg::ENTRIES_DEFAULT,
   parameter int PAGE_BITS = spr_pkg::PAGE_BITS_DEFAULT,
   parameter int REF_BITS  = spr_pkg::REF_BITS_DEFAULT,
   localparam int REQ_W       = spr_pkg::ID_BITS + 2 * PAGE_BITS,
   localparam int REQ_TDATA_W = ((REQ_W + 7) / 8) * 8,
   localparam int RES_W       = 2 * PAGE_BITS + 2,
   localparam int RSP_TDATA_W = ((RES_W + 7) / 8) * 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // tdata, low bit up: id, fresh_page, query_page, zero pad
   input  wire  [REQ_TDATA_W-1:0]           req_tdata,
   // tuser: mode
   input  wire  [spr_pkg::MODE_BITS-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // tdata, low bit up: page, took_fresh, freed_page, is_shared, zero pad
   output logic [RSP_TDATA_W-1:0]           rsp_tdata,
   // tuser: status
   output logic [spr_pkg::STATUS_BITS-1:0]  rsp_tuser
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDB      = spr_pkg::ID_BITS;

   spr_pkg::pkt_type    ctl   [0:ENTRIES];
   logic [IDB-1:0]      id    [0:ENTRIES];
   logic [PAGE_BITS-1:0] fresh [0:ENTRIES];
   logic [PAGE_BITS-1:0] qpage [0:ENTRIES];
   logic [IDX_BITS-1:0] hidx  [0:ENTRIES];
   logic [REF_BITS-1:0] hrefs [0:ENTRIES];
   logic [PAGE_BITS-1:0] hpage [0:ENTRIES];
   logic [IDX_BITS-1:0] fidx  [0:ENTRIES];

   spr_pkg::cmt_type    cmt;
   logic [IDX_BITS-1:0] cmt_idx;

   logic req_fire, done, out_pop;
   logic busy_ff, busy_in;

   logic                            out_valid_ff, out_valid_in;
   logic                            skid_valid_ff, skid_valid_in;
   logic [RES_W-1:0]                out_word_ff, out_word_in, skid_word_ff, skid_word_in;
   logic [spr_pkg::STATUS_BITS-1:0] out_stat_ff, out_stat_in, skid_stat_ff, skid_stat_in;

   assign req_tready = !busy_ff && !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      ctl[0].valid   = req_fire;
      ctl[0].mode    = req_tuser;
      ctl[0].hit     = 1'b0;
      ctl[0].free_ok = 1'b0;
      ctl[0].shared  = 1'b0;
      id[0]          = req_tdata[IDB-1:0];
      fresh[0]       = req_tdata[IDB +: PAGE_BITS];
      qpage[0]       = req_tdata[IDB + PAGE_BITS +: PAGE_BITS];
      hidx[0]        = '0;
      hrefs[0]       = '0;
      hpage[0]       = '0;
      fidx[0]        = '0;
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      spr_cell #(
         .IDX_BITS  (IDX_BITS),
         .MY_IDX    (g),
         .PAGE_BITS (PAGE_BITS),
         .REF_BITS  (REF_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl_i      (ctl[g]),
         .id_i       (id[g]),
         .fresh_i    (fresh[g]),
         .qpage_i    (qpage[g]),
         .hit_idx_i  (hidx[g]),
         .hit_refs_i (hrefs[g]),
         .hit_page_i (hpage[g]),
         .free_idx_i (fidx[g]),
         .ctl_o      (ctl[g+1]),
         .id_o       (id[g+1]),
         .fresh_o    (fresh[g+1]),
         .qpage_o    (qpage[g+1]),
         .hit_idx_o  (hidx[g+1]),
         .hit_refs_o (hrefs[g+1]),
         .hit_page_o (hpage[g+1]),
         .free_idx_o (fidx[g+1]),
         .cmt_i      (cmt),
         .cmt_idx_i  (cmt_idx),
         .cmt_id_i   (id[ENTRIES]),
         .cmt_page_i (fresh[ENTRIES])
      );
   end

   // Decide the outcome once the request has seen every entry.
   logic [spr_pkg::STATUS_BITS-1:0] r_status;
   logic [PAGE_BITS-1:0]            r_page, r_freed;
   logic                            r_took, r_shared;
   logic [RES_W-1:0]                r_word;

   assign done = ctl[ENTRIES].valid;

   always_comb begin
      r_status = spr_pkg::STATUS_OK;
      r_page   = '0;
      r_freed  = '0;
      r_took   = 1'b0;
      r_shared = 1'b0;
      cmt.en   = 1'b0;
      cmt.op   = spr_pkg::CMT_INC;
      cmt_idx  = hidx[ENTRIES];
      case (ctl[ENTRIES].mode)
         spr_pkg::MODE_OPEN: begin
            if (ctl[ENTRIES].hit) begin
               if (&hrefs[ENTRIES]) begin
                  r_status = spr_pkg::STATUS_OVERFLOW;
               end else begin
                  cmt.en = done;
                  r_page = hpage[ENTRIES];
               end
            end else if (!ctl[ENTRIES].free_ok) begin
               r_status = spr_pkg::STATUS_FULL;
            end else if (fresh[ENTRIES] == '0) begin
               r_status = spr_pkg::STATUS_ALLOC_FAIL;
            end else begin
               cmt.en  = done;
               cmt.op  = spr_pkg::CMT_NEW;
               cmt_idx = fidx[ENTRIES];
               r_page  = fresh[ENTRIES];
               r_took  = 1'b1;
            end
         end
         spr_pkg::MODE_CLOSE: begin
            if (!ctl[ENTRIES].hit) begin
               r_status = spr_pkg::STATUS_NOT_FOUND;
            end else if (hrefs[ENTRIES] <= REF_BITS'(1)) begin
               cmt.en  = done;
               cmt.op  = spr_pkg::CMT_FREE;
               r_freed = hpage[ENTRIES];
            end else begin
               cmt.en = done;
               cmt.op = spr_pkg::CMT_DEC;
            end
         end
         spr_pkg::MODE_QUERY: begin
            r_shared = ctl[ENTRIES].shared;
         end
         default: begin
            r_status = spr_pkg::STATUS_OK;
         end
      endcase
   end

   assign r_word = {r_shared, r_freed, r_took, r_page};

   // Output register with one skid entry behind it.
   assign out_pop = out_valid_ff && rsp_tready;

   always_comb begin
      busy_in       = busy_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      out_stat_in   = out_stat_ff;
      skid_word_in  = skid_word_ff;
      skid_stat_in  = skid_stat_ff;
      if (req_fire) begin
         busy_in = 1'b1;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (out_pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            out_stat_in   = skid_stat_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = done;
            out_word_in  = r_word;
            out_stat_in  = r_status;
         end
      end else if (done) begin
         skid_valid_in = 1'b1;
         skid_word_in  = r_word;
         skid_stat_in  = r_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      out_stat_ff  <= out_stat_in;
      skid_word_ff <= skid_word_in;
      skid_stat_ff <= skid_stat_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_word_ff);
   assign rsp_tuser  = out_stat_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/spr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks on the shared page reference-count table.
// ----------------------------------------------------------------------------
module spr_checker #(
   parameter int PAGE_BITS = spr_pkg::PAGE_BITS_DEFAULT,
   localparam int RES_W       = 2 * PAGE_BITS + 2,
   localparam int RSP_TDATA_W = ((RES_W + 7) / 8) * 8
) (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [RSP_TDATA_W-1:0]           rsp_tdata,
   input wire [spr_pkg::STATUS_BITS-1:0]  rsp_tuser
);

   logic [PAGE_BITS-1:0] c_page, c_freed;
   logic                 c_took;

   assign c_page  = rsp_tdata[PAGE_BITS-1:0];
   assign c_took  = rsp_tdata[PAGE_BITS];
   assign c_freed = rsp_tdata[PAGE_BITS + 1 +: PAGE_BITS];

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only one request is in the table's search row at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while one is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= spr_pkg::STATUS_OVERFLOW)
      else $error("status code out of range");

   // A consumed fresh page means a successful open of a real page.
   a_took_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && c_took |-> rsp_tuser == spr_pkg::STATUS_OK && c_page != '0)
      else $error("fresh page taken on a failed open");

   // A returned page comes only from a successful close, which opens nothing.
   a_freed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && c_freed != '0 |-> rsp_tuser == spr_pkg::STATUS_OK
                                      && c_page == '0 && !c_took)
      else $error("page freed with inconsistent result");

endmodule

bind shared_page_refcount_table spr_checker #(.PAGE_BITS(PAGE_BITS)) u_spr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
